// ===== hdl/pid_pkg.sv =====
package pid_pkg;

	// number formats
	localparam int FRAC_BITS  = 16;
	localparam int MAX_ITER   = 4096;
	localparam int VAL_W      = 32;
	localparam int OP_W       = VAL_W + 1;
	localparam int REG_W      = 24;
	localparam int GOP_W      = REG_W + 1;
	localparam int PROD_W     = OP_W + GOP_W;
	localparam int SHR_W      = PROD_W - FRAC_BITS;
	localparam int SUM_W      = VAL_W + 2;
	localparam int STATUS_W   = 2;
	localparam int PASS_OUT_W = 13;
	localparam int PASS_W     = $clog2(MAX_ITER + 1);
	localparam int CNT_W      = (PASS_W > PASS_OUT_W) ? PASS_W : PASS_OUT_W;
	localparam int IDX_W      = 3;

	// limits and fixed values
	localparam logic [OP_W-1:0]       HALF     = OP_W'(1) << (FRAC_BITS - 1);
	localparam logic [VAL_W-1:0]      NEG_ONE  = VAL_W'(~(VAL_W'(1) << FRAC_BITS) + VAL_W'(1));
	localparam logic [CNT_W-1:0]      ITER_LIM = CNT_W'(MAX_ITER);
	localparam logic [CNT_W-1:0]      PASS_SAT = CNT_W'((1 << PASS_OUT_W) - 1);

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP      = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_RCP  = 3'd4;

	// register reset values
	localparam logic [REG_W-1:0] RST_GAIN_P   = 24'd32768;
	localparam logic [REG_W-1:0] RST_GAIN_I   = 24'd1311;
	localparam logic [REG_W-1:0] RST_GAIN_D   = 24'd655;
	localparam logic [REG_W-1:0] RST_STEP     = 24'd6554;
	localparam logic [REG_W-1:0] RST_STEP_RCP = 24'd655360;

	// status codes
	localparam logic [STATUS_W-1:0] ST_CONVERGED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT     = 2'd2;

	typedef struct packed {
		logic [REG_W-1:0] gain_p;
		logic [REG_W-1:0] gain_i;
		logic [REG_W-1:0] gain_d;
		logic [REG_W-1:0] time_step;
		logic [REG_W-1:0] time_step_recip;
	} gains_t;

	// clamp a wide signed value into the signed value range
	function automatic logic [VAL_W-1:0] sat_val(input logic [SHR_W-1:0] v);
		logic [VAL_W-1:0] r;
		if (v[SHR_W-1:VAL_W-1] == '0 || v[SHR_W-1:VAL_W-1] == '1) begin
			r = v[VAL_W-1:0];
		end else if (v[SHR_W-1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== hdl/pid_regs.sv =====
module pid_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [pid_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pid_pkg::REG_W-1:0]  cfg_data,
	output pid_pkg::gains_t            gains
);
	import pid_pkg::*;

	gains_t gains_q;

	// configuration write, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.gain_p          <= RST_GAIN_P;
			gains_q.gain_i          <= RST_GAIN_I;
			gains_q.gain_d          <= RST_GAIN_D;
			gains_q.time_step       <= RST_STEP;
			gains_q.time_step_recip <= RST_STEP_RCP;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAIN_P:   gains_q.gain_p          <= cfg_data;
				REG_GAIN_I:   gains_q.gain_i          <= cfg_data;
				REG_GAIN_D:   gains_q.gain_d          <= cfg_data;
				REG_STEP:     gains_q.time_step       <= cfg_data;
				REG_STEP_RCP: gains_q.time_step_recip <= cfg_data;
				default: ;
			endcase
		end
	end

	assign gains = gains_q;

endmodule

// ===== hdl/pid_mul.sv =====
module pid_mul (
	input  logic                              clk,
	input  logic signed [pid_pkg::OP_W-1:0]   a,
	input  logic        [pid_pkg::REG_W-1:0]  g,
	output logic        [pid_pkg::VAL_W-1:0]  res
);
	import pid_pkg::*;

	logic signed [GOP_W-1:0]  g_s;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_q;

	// signed operand times unsigned gain, exact
	assign g_s    = signed'({1'b0, g});
	assign prod_d = a * g_s;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// dropping the fraction bits floors toward minus infinity
	assign res = sat_val(prod_q[PROD_W-1:FRAC_BITS]);

endmodule

// ===== hdl/pid_seq.sv =====
module pid_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pid_pkg::VAL_W-1:0]    measured_value,
	input  logic signed [pid_pkg::VAL_W-1:0]    setpoint,
	input  pid_pkg::gains_t                     gains,
	output logic signed [pid_pkg::OP_W-1:0]     mul_a,
	output logic        [pid_pkg::REG_W-1:0]    mul_g,
	input  logic        [pid_pkg::VAL_W-1:0]    mul_res,
	output logic                                busy,
	output logic                                done,
	output logic signed [pid_pkg::VAL_W-1:0]    final_value,
	output logic        [pid_pkg::STATUS_W-1:0] status,
	output logic        [pid_pkg::PASS_OUT_W-1:0] passes_used
);
	import pid_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_MP    = 4'd2;
	localparam logic [3:0] S_MDT   = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_MI    = 4'd5;
	localparam logic [3:0] S_MD    = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_ERR   = 4'd8;

	logic [3:0]              state_q;
	logic                    done_q;
	logic [CNT_W-1:0]        pass_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] target_q;
	logic signed [VAL_W-1:0] err_q;
	logic signed [VAL_W-1:0] prev_q;
	logic signed [VAL_W-1:0] acc_q;
	logic signed [VAL_W-1:0] pterm_q;
	logic signed [VAL_W-1:0] iterm_q;
	logic signed [VAL_W-1:0] deriv_q;
	logic signed [VAL_W-1:0] final_q;
	logic [STATUS_W-1:0]     status_q;
	logic [PASS_OUT_W-1:0]   passes_q;

	logic                    accept;
	logic                    reject;
	logic signed [OP_W-1:0]  err_ext;
	logic [OP_W-1:0]         err_abs;
	logic                    far;
	logic signed [SUM_W-1:0] start_diff;
	logic signed [SUM_W-1:0] err_diff;
	logic signed [SUM_W-1:0] acc_sum;
	logic signed [SUM_W-1:0] out_sum;
	logic signed [OP_W-1:0]  err_step;

	assign accept = start && (state_q == S_IDLE);
	assign reject = (measured_value <= 0) || (setpoint <= 0);

	// error magnitude against the half-unit band
	assign err_ext = OP_W'(err_q);
	assign err_abs = err_ext[OP_W-1] ? OP_W'(-err_ext) : OP_W'(err_ext);
	assign far     = err_abs > HALF;

	// widened adders, saturated by sat_val where a sum is registered
	assign start_diff = SUM_W'(setpoint) - SUM_W'(measured_value);
	assign err_diff   = SUM_W'(target_q) - SUM_W'(val_q);
	assign acc_sum    = SUM_W'(acc_q) + SUM_W'(signed'(mul_res));
	assign out_sum    = SUM_W'(pterm_q) + SUM_W'(iterm_q) + SUM_W'(signed'(mul_res));
	assign err_step   = OP_W'(err_q) - OP_W'(prev_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_g = '0;
		case (state_q)
			S_MP: begin
				mul_a = OP_W'(err_q);
				mul_g = gains.gain_p;
			end
			S_MDT: begin
				mul_a = OP_W'(err_q);
				mul_g = gains.time_step;
			end
			S_ACC: begin
				mul_a = err_step;
				mul_g = gains.time_step_recip;
			end
			S_MI: begin
				mul_a = OP_W'(acc_q);
				mul_g = gains.gain_i;
			end
			S_MD: begin
				mul_a = OP_W'(deriv_q);
				mul_g = gains.gain_d;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (reject) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (far && pass_q < ITER_LIM) begin
						state_q <= S_MP;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_MP:    state_q <= S_MDT;
				S_MDT:   state_q <= S_ACC;
				S_ACC:   state_q <= S_MI;
				S_MI:    state_q <= S_MD;
				S_MD:    state_q <= S_SUM;
				S_SUM:   state_q <= S_ERR;
				S_ERR:   state_q <= S_CHECK;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, restarted for every item
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q    <= measured_value;
					target_q <= setpoint;
					err_q    <= sat_val(SHR_W'(start_diff));
					acc_q    <= '0;
					prev_q   <= '0;
					pass_q   <= '0;
					if (reject) begin
						final_q  <= NEG_ONE;
						status_q <= ST_REJECTED;
						passes_q <= '0;
					end
				end
			end
			S_CHECK: begin
				if (!(far && pass_q < ITER_LIM)) begin
					final_q  <= val_q;
					status_q <= far ? ST_LIMIT : ST_CONVERGED;
					passes_q <= (pass_q > PASS_SAT) ? PASS_SAT[PASS_OUT_W-1:0]
						: pass_q[PASS_OUT_W-1:0];
				end
			end
			S_MDT: pterm_q <= mul_res;
			S_ACC: acc_q   <= sat_val(SHR_W'(acc_sum));
			S_MI:  deriv_q <= mul_res;
			S_MD:  iterm_q <= mul_res;
			S_SUM: val_q   <= sat_val(SHR_W'(out_sum));
			S_ERR: begin
				prev_q <= err_q;
				err_q  <= sat_val(SHR_W'(err_diff));
				pass_q <= pass_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign final_value = final_q;
	assign status      = status_q;
	assign passes_used = passes_q;

endmodule

// ===== hdl/pid_iterate_to_setpoint_core.sv =====
// PID settle unit: runs a PID loop, whose output feeds back as the next
// measured value, until it lands within 0.5 of the setpoint or the pass limit is hit.
//
// Input: pulse start with measured_value and setpoint (signed Q16.16); the
// transfer happens at a clock edge where start is high and busy is low.
// Output: done is high for exactly one cycle while final_value, status and
// passes_used carry the result; the receiver must take it in that cycle.
// Configuration: cfg_write, cfg_index and cfg_data write a gain, dt or 1/dt
// register at the clock edge; write only while busy is low (not enforced).
//
// Sequence: a rejected item gives done in the cycle after its transfer;
// otherwise a check state comes first and after every pass, and each pass
// steps through MP, MDT, ACC, MI, MD, SUM and ERR because its five products
// go one after another through a single registered multiplier. Up to 4096
// passes are run. busy stays high for the whole run; a new item may be
// started in the cycle that done is shown.
// Reset: arst_n clears the sequencer and loads the register defaults.
module pid_iterate_to_setpoint_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [pid_pkg::VAL_W-1:0]    measured_value,
	input  logic signed [pid_pkg::VAL_W-1:0]    setpoint,
	output logic                                done,
	output logic signed [pid_pkg::VAL_W-1:0]    final_value,
	output logic        [pid_pkg::STATUS_W-1:0] status,
	output logic        [pid_pkg::PASS_OUT_W-1:0] passes_used,
	input  logic                                cfg_write,
	input  logic        [pid_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [pid_pkg::REG_W-1:0]    cfg_data
);
	import pid_pkg::*;

	gains_t                  gains;
	logic signed [OP_W-1:0]  mul_a;
	logic [REG_W-1:0]        mul_g;
	logic [VAL_W-1:0]        mul_res;

	// configuration registers
	pid_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gains     (gains)
	);

	// shared multiplier
	pid_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.g   (mul_g),
		.res (mul_res)
	);

	// sequencer and working registers
	pid_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.measured_value (measured_value),
		.setpoint       (setpoint),
		.gains          (gains),
		.mul_a          (mul_a),
		.mul_g          (mul_g),
		.mul_res        (mul_res),
		.busy           (busy),
		.done           (done),
		.final_value    (final_value),
		.status         (status),
		.passes_used    (passes_used)
	);

endmodule

// ===== tb/sv/pid_settle_checker.sv =====
`timescale 1ns / 100ps

module pid_settle_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [pid_pkg::VAL_W-1:0]    measured_value,
	input  logic signed [pid_pkg::VAL_W-1:0]    setpoint,
	input  logic                                done,
	input  logic signed [pid_pkg::VAL_W-1:0]    final_value,
	input  logic        [pid_pkg::STATUS_W-1:0] status,
	input  logic        [pid_pkg::PASS_OUT_W-1:0] passes_used,
	input  logic                                cfg_write,
	input  logic        [pid_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [pid_pkg::REG_W-1:0]    cfg_data,
	output int                                  fail_count,
	output int                                  pending_results
);
	import pid_pkg::*;

	localparam longint VAL_HI = (longint'(1) <<< (VAL_W - 1)) - 1;
	localparam longint VAL_LO = -(longint'(1) <<< (VAL_W - 1));
	localparam int     REPORT_LIMIT = 10;

	typedef struct {
		logic signed [VAL_W-1:0]      final_value;
		logic        [STATUS_W-1:0]   status;
		logic        [PASS_OUT_W-1:0] passes_used;
	} settle_result_t;

	gains_t         loop_gains;
	settle_result_t settle_expected[$];
	settle_result_t want;
	int             mismatch_total;

	// clamp to the signed value range
	function automatic longint clamp_val(input longint v);
		if (v > VAL_HI) begin
			return VAL_HI;
		end
		if (v < VAL_LO) begin
			return VAL_LO;
		end
		return v;
	endfunction

	// exact product, floor shift by the fraction width, then clamp
	function automatic longint scaled_product(input longint a, input logic [REG_W-1:0] g);
		longint gw;
		gw = longint'({1'b0, g});
		return clamp_val((a * gw) >>> FRAC_BITS);
	endfunction

	// run the whole settle loop for one item
	function automatic settle_result_t settle_predict(
		input logic signed [VAL_W-1:0] start_value,
		input logic signed [VAL_W-1:0] target_value,
		input gains_t                  g
	);
		settle_result_t r;
		longint val, tgt, err, acc, prev_err, pterm, iterm, dterm, deriv, half;
		int     passes;
		val    = start_value;
		tgt    = target_value;
		half   = HALF;
		acc    = 0;
		prev_err = 0;
		passes = 0;
		if (val <= 0 || tgt <= 0) begin
			r.final_value = NEG_ONE;
			r.status      = ST_REJECTED;
			r.passes_used = '0;
			return r;
		end
		err = clamp_val(tgt - val);
		while ((err < 0 ? -err : err) > half && passes < MAX_ITER) begin
			pterm    = scaled_product(err, g.gain_p);
			acc      = clamp_val(acc + scaled_product(err, g.time_step));
			iterm    = scaled_product(acc, g.gain_i);
			deriv    = scaled_product(err - prev_err, g.time_step_recip);
			dterm    = scaled_product(deriv, g.gain_d);
			prev_err = err;
			val      = clamp_val(pterm + iterm + dterm);
			err      = clamp_val(tgt - val);
			passes++;
		end
		r.final_value = VAL_W'(val);
		r.status      = ((err < 0 ? -err : err) > half) ? ST_LIMIT : ST_CONVERGED;
		r.passes_used = (passes > int'(PASS_SAT)) ? PASS_OUT_W'(PASS_SAT)
			: PASS_OUT_W'(passes);
		return r;
	endfunction

	// track register writes, predict on input transfers, compare on results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_gains.gain_p          <= RST_GAIN_P;
			loop_gains.gain_i          <= RST_GAIN_I;
			loop_gains.gain_d          <= RST_GAIN_D;
			loop_gains.time_step       <= RST_STEP;
			loop_gains.time_step_recip <= RST_STEP_RCP;
			settle_expected.delete();
			mismatch_total  = 0;
			fail_count      <= 0;
			pending_results <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_GAIN_P:   loop_gains.gain_p          <= cfg_data;
					REG_GAIN_I:   loop_gains.gain_i          <= cfg_data;
					REG_GAIN_D:   loop_gains.gain_d          <= cfg_data;
					REG_STEP:     loop_gains.time_step       <= cfg_data;
					REG_STEP_RCP: loop_gains.time_step_recip <= cfg_data;
					default: ;
				endcase
			end

			// result transfer against the oldest expectation
			if (done) begin
				if (settle_expected.size() == 0) begin
					if (mismatch_total < REPORT_LIMIT) begin
						$display("%0t: unexpected result final_value %h status %0d",
							$realtime, final_value, status);
						$display("    passes_used %0d", passes_used);
					end
					mismatch_total++;
				end else begin
					want = settle_expected.pop_front();
					if (final_value !== want.final_value || status !== want.status ||
						passes_used !== want.passes_used) begin
						if (mismatch_total < REPORT_LIMIT) begin
							$display("%0t: mismatch final_value exp %h got %h",
								$realtime, want.final_value, final_value);
							$display("    status exp %0d got %0d, passes_used exp %0d got %0d",
								want.status, status, want.passes_used, passes_used);
						end
						mismatch_total++;
					end
				end
			end

			// input transfer
			if (start && !busy) begin
				settle_expected.push_back(settle_predict(measured_value, setpoint, loop_gains));
			end

			pending_results <= settle_expected.size();
			fail_count      <= mismatch_total;
		end
	end

endmodule

// ===== tb/sv/tb_pid_iterate_to_setpoint_core.sv =====
`timescale 1ns / 100ps

module tb_pid_iterate_to_setpoint_core;
	import pid_pkg::*;

	localparam int GAP_MAX      = 18;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 15_000_000;
	localparam int HALF_INT     = 1 << (FRAC_BITS - 1);
	localparam int ONE_INT      = 1 << FRAC_BITS;

	localparam logic signed [VAL_W-1:0] Q_ONE      = VAL_W'(ONE_INT);
	localparam logic signed [VAL_W-1:0] Q_HALF     = VAL_W'(HALF_INT);
	localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic        [REG_W-1:0] REG_ONES   = {REG_W{1'b1}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic signed [VAL_W-1:0]       measured_value = '0;
	logic signed [VAL_W-1:0]       setpoint = '0;
	logic                          done;
	logic signed [VAL_W-1:0]       final_value;
	logic        [STATUS_W-1:0]    status;
	logic        [PASS_OUT_W-1:0]  passes_used;
	logic                          cfg_write = 1'b0;
	logic        [IDX_W-1:0]       cfg_index = '0;
	logic        [REG_W-1:0]       cfg_data = '0;

	int fail_count;
	int pending_results;
	int cycle_count = 0;
	int gap_max = GAP_MAX;

	always #2 clk = ~clk;

	pid_iterate_to_setpoint_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.measured_value (measured_value),
		.setpoint       (setpoint),
		.done           (done),
		.final_value    (final_value),
		.status         (status),
		.passes_used    (passes_used),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	pid_settle_checker settle_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.measured_value  (measured_value),
		.setpoint        (setpoint),
		.done            (done),
		.final_value     (final_value),
		.status          (status),
		.passes_used     (passes_used),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// run-time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one item: random hold-off, then hold start until the transfer
	task automatic send_item(input logic signed [VAL_W-1:0] mv, input logic signed [VAL_W-1:0] sp);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		measured_value <= mv;
		setpoint       <= sp;
		do @(posedge clk); while (busy);
	endtask

	// mostly well-formed pairs, some close pairs, some raw noise
	task automatic send_random;
		int                      kind;
		logic signed [VAL_W-1:0] mv;
		logic signed [VAL_W-1:0] sp;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			mv = $urandom;
			sp = $urandom;
		end else if (kind == 1) begin
			mv = $urandom_range(1, 32'h7FFE_0000);
			sp = mv + VAL_W'($urandom_range(0, 2 * HALF_INT)) - VAL_W'(HALF_INT);
		end else begin
			mv = $urandom_range(1, 32'h7FFF_FFFF);
			sp = $urandom_range(1, 32'h7FFF_FFFF);
		end
		send_item(mv, sp);
	endtask

	// stop sending until every expected result has come back
	task automatic wait_drained;
		start <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// full register set, then writes to unused indexes that must be ignored
	task automatic write_regs(
		input logic [REG_W-1:0] gp,
		input logic [REG_W-1:0] gi,
		input logic [REG_W-1:0] gd,
		input logic [REG_W-1:0] dt,
		input logic [REG_W-1:0] rcp
	);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_STEP, dt);
		write_reg(REG_STEP_RCP, rcp);
		for (int k = int'(REG_STEP_RCP) + 1; k < (1 << IDX_W); k++) begin
			write_reg(IDX_W'(k), REG_W'($urandom));
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: rejects, already close, thresholds, slow and limit runs
		send_item(Q_ONE, -Q_ONE);
		send_item(-Q_ONE, Q_ONE);
		send_item('0, Q_ONE);
		send_item(Q_ONE, '0);
		send_item(VAL_BOTTOM, VAL_BOTTOM);
		send_item(VAL_TOP, VAL_BOTTOM);
		send_item(5 * Q_ONE, 5 * Q_ONE);
		send_item(5 * Q_ONE, 5 * Q_ONE + Q_HALF);
		send_item(5 * Q_ONE + Q_HALF, 5 * Q_ONE);
		send_item(5 * Q_ONE, 5 * Q_ONE + Q_HALF + 1);
		send_item(VAL_TOP, VAL_TOP);
		send_item(1, 1);
		send_item(Q_ONE, 2 * Q_ONE);
		send_item(3 * Q_ONE, Q_ONE);
		send_item(1, VAL_TOP);
		send_item(VAL_TOP, 1);
		wait_drained;

		// every register at its top value
		write_regs(REG_ONES, REG_ONES, REG_ONES, REG_ONES, REG_ONES);
		send_item(Q_ONE, 100 * Q_ONE);
		send_item(VAL_TOP, 1);
		send_item(2 * Q_ONE, 2 * Q_ONE);
		wait_drained;

		// every register zero: output stuck at zero
		write_regs('0, '0, '0, '0, '0);
		send_item(Q_ONE, 2 * Q_ONE);
		send_item(2 * Q_ONE, 2 * Q_ONE + Q_HALF / 2);
		send_item(-1, 5 * Q_ONE);
		wait_drained;

		// pure integral with unit gains: settles in a couple of passes
		write_regs('0, REG_W'(ONE_INT), '0, REG_W'(ONE_INT), REG_W'(ONE_INT));
		gap_max = 0;
		repeat (30) send_random();
		gap_max = GAP_MAX;
		repeat (30) send_random();
		wait_drained;

		// random stable mixes of all three terms
		repeat (4) begin
			write_regs(REG_W'($urandom_range(0, ONE_INT / 4)),
				REG_W'($urandom_range(3 * ONE_INT / 4, ONE_INT)),
				REG_W'($urandom_range(0, ONE_INT / 32)),
				REG_W'(ONE_INT),
				REG_W'($urandom_range(1, ONE_INT)));
			repeat (10) send_random();
			wait_drained;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pid_pkg.sv
hdl/pid_regs.sv
hdl/pid_mul.sv
hdl/pid_seq.sv
hdl/pid_iterate_to_setpoint_core.sv
tb/sv/pid_settle_checker.sv
tb/sv/tb_pid_iterate_to_setpoint_core.sv
